// ===== rtl/echo_range_moving_average_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the echo range moving average block
// Clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ECHO_RANGE_MOVING_AVERAGE_ASSERT_SVH
`define ECHO_RANGE_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication.
`define ERMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ERMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/erma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erma_pkg
// Widths, register codes, reset values and controller/datapath link types.
// ----------------------------------------------------------------------------
package erma_pkg;

  localparam int ECHO_W     = 16;
  localparam int PRE_W      = 11;
  localparam int OFF_W      = 16;
  localparam int GAIN_W     = 24;
  localparam int SPAN_W     = 16;
  localparam int POS_W      = 16;
  localparam int FRAC_W     = 16;
  // ticks * prescale / 16: the divide by 16 is a 4 bit shift
  localparam int US_SHIFT   = 4;
  localparam int US_W       = ECHO_W + PRE_W - US_SHIFT;
  localparam int MA_W       = 23;
  localparam int MB_W       = 24;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int WINDOW_LEN_DEF = 8;

  localparam logic [PRE_W-1:0]  PRESCALE_RST = PRE_W'(64);
  localparam logic [OFF_W-1:0]  OFFSET_RST   = '0;
  localparam logic [GAIN_W-1:0] GAIN_RST     = GAIN_W'(65536);
  localparam logic [SPAN_W-1:0] SPAN_RST     = SPAN_W'(10000);

  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PRESCALE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_OFFSET   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_US  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_SPAN     = CFG_IDX_W'(3);

  typedef enum logic [2:0] {
    MUL_HOLD,
    MUL_TICK_US,
    MUL_AVG_US,
    MUL_GAIN,
    MUL_RECIP,
    MUL_BACK
  } mul_op_t;

  typedef struct packed {
    mul_op_t mul_op;
    logic    load_ticks;
    logic    load_motor;
    logic    update_win;
    logic    load_q;
    logic    correct_q;
    logic    load_held;
    logic    load_acc;
    logic    acc_val;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic reject;
  } stat_t;

endpackage

// ===== rtl/echo_range_moving_average.sv =====
`timescale 1ns / 1ps
`include "echo_range_moving_average_assert.svh"
// ----------------------------------------------------------------------------
// echo_range_moving_average
// Echo time to encoder position, range gate and ring-window moving average.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+----------------------------------
//  in      | input     | in_valid/in_ready | in_echo_time[15:0]
//  out     | output    | out_valid/ready   | out_accepted, out_position_ref
//  cfg     | input     | cfg_valid/ready   | cfg_index[2:0], cfg_wdata[23:0]
//
//  An item is taken only while the sequencer is idle, and each multiply goes
//  through the one 23x24 multiplier (echo to microseconds, gain, reciprocal
//  divide by the window length, back-multiply, then the same two conversions
//  for the average); an out-of-range item skips the window and the average.
//  Reset (rst_n low, synchronous) clears config to defaults, the window,
//  its sum and the held position; window entries read as zero until written.
//  A result waits in the output register while the next item is taken;
//  the sequencer stalls only when a new result finds that register full.
//
module echo_range_moving_average #(
  parameter int WINDOW_LEN = erma_pkg::WINDOW_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input item
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [erma_pkg::ECHO_W-1:0]         in_echo_time,
  // result item
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_accepted,
  output logic signed [erma_pkg::POS_W-1:0]   out_position_ref,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [erma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [erma_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import erma_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Registers are always writable; writes land only while idle by contract.
  assign cfg_ready = 1'b1;

  // Sequencer: issues one datapath command set per cycle
  erma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: config, multiplier, window ring and output register
  erma_datapath #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_echo_time     (in_echo_time),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_accepted     (out_accepted),
    .out_position_ref (out_position_ref)
  );

  // One item at a time: an accepted item closes the input until it is done.
  `ERMA_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "item accepted while busy")
  // Never overwrite a result that has not been taken.
  `ERMA_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid || out_ready, "result overwritten")
  // The window only moves for an in-range echo.
  `ERMA_ASSERT_IMP(a_update_in_range, cmd.update_win, !stat.reject, "rejected echo in window")

endmodule

// ===== rtl/erma_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erma_datapath
// Config registers, shared multiplier, window ring, sum and position logic.
// ----------------------------------------------------------------------------
module erma_datapath #(
  parameter int WINDOW_LEN = erma_pkg::WINDOW_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  erma_pkg::cmd_t                       cmd,
  output erma_pkg::stat_t                      stat,
  input  logic [erma_pkg::ECHO_W-1:0]          in_echo_time,
  input  logic                                 cfg_we,
  input  logic [erma_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [erma_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                 out_accepted,
  output logic signed [erma_pkg::POS_W-1:0]    out_position_ref
);
  import erma_pkg::*;

  localparam int IDX_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W   = ECHO_W + $clog2(WINDOW_LEN);
  localparam int HQ_W    = SPAN_W - 1 + FRAC_W;
  localparam int INT_W   = PROD_W - FRAC_W;
  localparam logic [MB_W-1:0]  RECIP     = MB_W'((64'd1 << SUM_W) / WINDOW_LEN);
  localparam logic [MB_W-1:0]  LEN_MB    = MB_W'(WINDOW_LEN);
  localparam logic [SUM_W-1:0] LEN_SUM   = SUM_W'(WINDOW_LEN);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_LEN - 1);
  localparam logic [INT_W-1:0] POS_MAX_I = INT_W'(2 ** (POS_W - 1) - 1);
  localparam logic [POS_W-1:0] POS_MAX   = POS_W'(2 ** (POS_W - 1) - 1);

  logic [PRE_W-1:0]      prescale_r;
  logic [OFF_W-1:0]      offset_r;
  logic [GAIN_W-1:0]     gain_r;
  logic [SPAN_W-1:0]     span_r;
  logic [ECHO_W-1:0]     ticks_r;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [US_W-1:0]       motor_r, motor_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [IDX_W-1:0]      slot_r, slot_nxt;
  logic [WINDOW_LEN-1:0] valid_r;
  logic [ECHO_W-1:0]     mem [WINDOW_LEN];
  logic [ECHO_W-1:0]     rd_r;
  logic [ECHO_W-1:0]     q_r;
  logic [POS_W-1:0]      held_r, pos_nxt;
  logic                  acc_r;
  logic                  out_accepted_r;
  logic [POS_W-1:0]      out_position_r;

  logic [MA_W-1:0]       mul_a;
  logic [MB_W-1:0]       mul_b;
  logic [US_W-1:0]       us;
  logic [ECHO_W-1:0]     q0;
  logic [SUM_W-1:0]      rem;
  logic [ECHO_W-1:0]     old_val;
  logic [SPAN_W-2:0]     half;
  logic [PROD_W-1:0]     half_q;
  logic                  at_or_above;
  logic [PROD_W-1:0]     above;
  logic [HQ_W-1:0]       below;
  logic [INT_W-1:0]      above_int;
  logic [POS_W-2:0]      below_int;

  // Shared multiplier operand select
  always_comb begin
    case (cmd.mul_op)
      MUL_TICK_US: begin
        mul_a = MA_W'(ticks_r);
        mul_b = MB_W'(prescale_r);
      end
      MUL_AVG_US: begin
        mul_a = MA_W'(q_r);
        mul_b = MB_W'(prescale_r);
      end
      MUL_GAIN: begin
        mul_a = MA_W'(motor_r);
        mul_b = MB_W'(gain_r);
      end
      MUL_RECIP: begin
        mul_a = MA_W'(sum_r);
        mul_b = RECIP;
      end
      MUL_BACK: begin
        mul_a = MA_W'(q0);
        mul_b = LEN_MB;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = (cmd.mul_op == MUL_HOLD) ? prod_r : PROD_W'(mul_a) * PROD_W'(mul_b);

  // Microseconds and offset floor
  assign us        = prod_r[US_SHIFT +: US_W];
  assign motor_nxt = (us > US_W'(offset_r)) ? us - US_W'(offset_r) : '0;

  // Reciprocal quotient estimate, then the one-step correction
  assign q0  = prod_r[SUM_W +: ECHO_W];
  assign rem = sum_r - prod_r[SUM_W-1:0];

  // Position from the scaled product
  assign half        = span_r[SPAN_W-1:1];
  assign half_q      = PROD_W'({half, {FRAC_W{1'b0}}});
  assign at_or_above = prod_r >= half_q;
  assign above       = prod_r - half_q;
  assign above_int   = above[PROD_W-1:FRAC_W];
  assign below       = half_q[HQ_W-1:0] - prod_r[HQ_W-1:0];
  assign below_int   = below[HQ_W-1:FRAC_W];
  assign stat.reject = at_or_above && (above_int > INT_W'(half));

  always_comb begin
    if (at_or_above) begin
      pos_nxt = (above_int > POS_MAX_I) ? POS_MAX : above_int[POS_W-1:0];
    end else begin
      pos_nxt = POS_W'(0) - POS_W'(below_int);
    end
  end

  // Window bookkeeping
  assign old_val  = valid_r[slot_r] ? rd_r : '0;
  assign sum_nxt  = sum_r - SUM_W'(old_val) + SUM_W'(ticks_r);
  assign slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= PRESCALE_RST;
      offset_r   <= OFFSET_RST;
      gain_r     <= GAIN_RST;
      span_r     <= SPAN_RST;
      sum_r      <= '0;
      slot_r     <= '0;
      valid_r    <= '0;
      held_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMER_PRESCALE: prescale_r <= cfg_wdata[PRE_W-1:0];
          CFG_MOTOR_OFFSET:   offset_r   <= cfg_wdata[OFF_W-1:0];
          CFG_COUNTS_PER_US:  gain_r     <= cfg_wdata[GAIN_W-1:0];
          CFG_BOARD_SPAN:     span_r     <= cfg_wdata[SPAN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.update_win) begin
        sum_r           <= sum_nxt;
        slot_r          <= slot_nxt;
        valid_r[slot_r] <= 1'b1;
      end
      if (cmd.load_held) begin
        held_r <= pos_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load_ticks) begin
      ticks_r <= in_echo_time;
    end
    if (cmd.load_motor) begin
      motor_r <= motor_nxt;
    end
    if (cmd.load_q) begin
      q_r <= q0;
    end else if (cmd.correct_q && (rem >= LEN_SUM)) begin
      q_r <= q_r + 1'b1;
    end
    if (cmd.load_acc) begin
      acc_r <= cmd.acc_val;
    end
    if (cmd.load_out) begin
      out_accepted_r <= acc_r;
      out_position_r <= held_r;
    end
  end

  // Window ring memory, registered read of the slot to be replaced
  always_ff @(posedge clk) begin
    if (cmd.update_win) begin
      mem[slot_r] <= ticks_r;
    end
    rd_r <= mem[slot_r];
  end

  assign out_accepted     = out_accepted_r;
  assign out_position_ref = $signed(out_position_r);

endmodule

// ===== rtl/erma_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erma_ctrl
// Sequencer for convert, check, window update, divide and reconvert.
// ----------------------------------------------------------------------------
module erma_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  erma_pkg::stat_t stat,
  output erma_pkg::cmd_t  cmd
);
  import erma_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_TUS   = 14'b00000000000010,
    S_TMOT  = 14'b00000000000100,
    S_TGAIN = 14'b00000000001000,
    S_TCHK  = 14'b00000000010000,
    S_UPD   = 14'b00000000100000,
    S_DM    = 14'b00000001000000,
    S_DB    = 14'b00000010000000,
    S_DC    = 14'b00000100000000,
    S_AUS   = 14'b00001000000000,
    S_AMOT  = 14'b00010000000000,
    S_AGAIN = 14'b00100000000000,
    S_AEVAL = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_op = MUL_HOLD;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_ticks = 1'b1;
          state_nxt      = S_TUS;
        end
      end
      S_TUS: begin
        cmd.mul_op = MUL_TICK_US;
        state_nxt  = S_TMOT;
      end
      S_TMOT: begin
        cmd.load_motor = 1'b1;
        state_nxt      = S_TGAIN;
      end
      S_TGAIN: begin
        cmd.mul_op = MUL_GAIN;
        state_nxt  = S_TCHK;
      end
      S_TCHK: begin
        cmd.load_acc = 1'b1;
        cmd.acc_val  = !stat.reject;
        state_nxt    = stat.reject ? S_OUT : S_UPD;
      end
      S_UPD: begin
        cmd.update_win = 1'b1;
        state_nxt      = S_DM;
      end
      S_DM: begin
        cmd.mul_op = MUL_RECIP;
        state_nxt  = S_DB;
      end
      S_DB: begin
        cmd.mul_op = MUL_BACK;
        cmd.load_q = 1'b1;
        state_nxt  = S_DC;
      end
      S_DC: begin
        cmd.correct_q = 1'b1;
        state_nxt     = S_AUS;
      end
      S_AUS: begin
        cmd.mul_op = MUL_AVG_US;
        state_nxt  = S_AMOT;
      end
      S_AMOT: begin
        cmd.load_motor = 1'b1;
        state_nxt      = S_AGAIN;
      end
      S_AGAIN: begin
        cmd.mul_op = MUL_GAIN;
        state_nxt  = S_AEVAL;
      end
      S_AEVAL: begin
        cmd.load_held = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== dv/echo_range_moving_average_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_range_moving_average_checker
// Watches the register, echo and position channels, keeps its own copy of
// the settings and the averaging window, and compares every result item.
// ----------------------------------------------------------------------------
module echo_range_moving_average_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [erma_pkg::ECHO_W-1:0]         in_echo_time,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_accepted,
  input  logic signed [erma_pkg::POS_W-1:0]   out_position_ref,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [erma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [erma_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int unsigned                         fail_count,
  output int unsigned                         pending_count,
  output int unsigned                         checked_count,
  output int unsigned                         in_range_count
);
  import erma_pkg::*;

  localparam int RING_LEN  = WINDOW_LEN_DEF;
  localparam int SLOT_W    = $clog2(RING_LEN);
  localparam int SUM_W     = ECHO_W + SLOT_W;
  localparam int RAW_W     = ECHO_W + PRE_W;
  localparam int SCL_W     = US_W + GAIN_W;
  localparam longint POS_MAX = (64'sd1 <<< (POS_W - 1)) - 1;
  localparam longint POS_MIN = -(64'sd1 <<< (POS_W - 1));

  typedef struct packed {
    logic                    accepted;
    logic signed [POS_W-1:0] position;
  } echo_result_t;

  logic [PRE_W-1:0]        prescale_q;
  logic [OFF_W-1:0]        offset_q;
  logic [GAIN_W-1:0]       gain_q;
  logic [SPAN_W-1:0]       span_q;

  logic [ECHO_W-1:0]       ring [RING_LEN];
  logic [SUM_W-1:0]        ring_sum;
  logic [SLOT_W-1:0]       ring_slot;
  logic signed [POS_W-1:0] last_position;

  echo_result_t            result_q [$];
  echo_result_t            want;
  int unsigned             n_fail;
  int unsigned             n_checked;
  int unsigned             n_in_range;
  longint                  half_span;
  longint                  echo_pos;
  longint                  avg_pos;

  // Ticks -> microseconds -> motor distance -> encoder counts, truncated
  // toward zero around the board center.
  function automatic longint echo_to_position(logic [ECHO_W-1:0] ticks);
    logic [RAW_W-1:0]  raw;
    logic [US_W-1:0]   us;
    logic [US_W-1:0]   motor;
    logic [SCL_W-1:0]  scaled;
    logic [SCL_W-1:0]  half_q;
    logic [SCL_W-1:0]  diff;
    raw    = RAW_W'(ticks) * RAW_W'(prescale_q);
    us     = raw[US_SHIFT +: US_W];
    motor  = (us <= US_W'(offset_q)) ? '0 : us - US_W'(offset_q);
    scaled = SCL_W'(motor) * SCL_W'(gain_q);
    half_q = SCL_W'({span_q[SPAN_W-1:1], FRAC_W'(0)});
    if (scaled >= half_q) begin
      diff = (scaled - half_q) >> FRAC_W;
      return longint'(diff);
    end
    diff = (half_q - scaled) >> FRAC_W;
    return -longint'(diff);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      prescale_q    = PRESCALE_RST;
      offset_q      = OFFSET_RST;
      gain_q        = GAIN_RST;
      span_q        = SPAN_RST;
      for (int i = 0; i < RING_LEN; i++) ring[i] = '0;
      ring_sum      = '0;
      ring_slot     = '0;
      last_position = '0;
      result_q.delete();
      n_fail        = 0;
      n_checked     = 0;
      n_in_range    = 0;
    end else begin
      // Retire the oldest expectation against the result item taken here.
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result item with no expectation: accepted %0d position_ref %0d",
                 out_accepted, out_position_ref);
          n_fail++;
        end else begin
          want = result_q.pop_front();
          n_checked++;
          if (out_accepted !== want.accepted) begin
            $error("accepted: expected %0d, actual %0d", want.accepted, out_accepted);
            n_fail++;
          end
          if (out_position_ref !== want.position) begin
            $error("position_ref: expected %0d, actual %0d",
                   $signed(want.position), out_position_ref);
            n_fail++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TIMER_PRESCALE: prescale_q = cfg_wdata[PRE_W-1:0];
          CFG_MOTOR_OFFSET:   offset_q   = cfg_wdata[OFF_W-1:0];
          CFG_COUNTS_PER_US:  gain_q     = cfg_wdata[GAIN_W-1:0];
          CFG_BOARD_SPAN:     span_q     = cfg_wdata[SPAN_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        half_span = longint'(span_q >> 1);
        echo_pos  = echo_to_position(in_echo_time);
        if (echo_pos > half_span || echo_pos < -half_span) begin
          want.accepted = 1'b0;
        end else begin
          ring_sum        = ring_sum - SUM_W'(ring[ring_slot]) + SUM_W'(in_echo_time);
          ring[ring_slot] = in_echo_time;
          ring_slot       = ring_slot + 1'b1;
          avg_pos = echo_to_position(ECHO_W'(ring_sum / RING_LEN));
          if (avg_pos > POS_MAX) avg_pos = POS_MAX;
          if (avg_pos < POS_MIN) avg_pos = POS_MIN;
          last_position = avg_pos[POS_W-1:0];
          want.accepted = 1'b1;
          n_in_range++;
        end
        want.position = last_position;
        result_q.push_back(want);
      end
    end
    fail_count     <= n_fail;
    pending_count  <= result_q.size();
    checked_count  <= n_checked;
    in_range_count <= n_in_range;
  end

endmodule

// ===== dv/echo_range_moving_average_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_range_moving_average_tb
// Drives echo times and register writes into the block under bursty sender
// and stalling receiver behavior; the checker beside it predicts every
// result item and reports mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module echo_range_moving_average_tb;
  import erma_pkg::*;

  // First register index that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_BOARD_SPAN + 1'b1;
  localparam int                   ECHO_MAX      = (1 << ECHO_W) - 1;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_SQUARE
  } ready_mode_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [ECHO_W-1:0]          in_echo_time = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_accepted;
  logic signed [POS_W-1:0]    out_position_ref;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  int unsigned                fail_count;
  int unsigned                pending_count;
  int unsigned                checked_count;
  int unsigned                in_range_count;

  // Settings as last written; used only to aim random echo times at the
  // edge of the accepted range.
  logic [PRE_W-1:0]           cur_prescale = PRESCALE_RST;
  logic [OFF_W-1:0]           cur_offset   = OFFSET_RST;
  logic [GAIN_W-1:0]          cur_gain     = GAIN_RST;
  logic [SPAN_W-1:0]          cur_span     = SPAN_RST;

  int unsigned                items_sent;
  int unsigned                settings_applied;
  int unsigned                burst_left;

  ready_mode_t                ready_mode = RDY_ALWAYS;
  int unsigned                ready_left = 0;
  logic [7:0]                 ready_tick = '0;

  always #5 clk = ~clk;

  echo_range_moving_average uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_echo_time     (in_echo_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_accepted     (out_accepted),
    .out_position_ref (out_position_ref),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  echo_range_moving_average_checker position_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_echo_time     (in_echo_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_accepted     (out_accepted),
    .out_position_ref (out_position_ref),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .checked_count    (checked_count),
    .in_range_count   (in_range_count)
  );

  // Receiver: pick a stall style for a random stretch of cycles, from
  // always ready through coin flips and sparse acceptance to a square wave.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_left <= $urandom_range(20, 120);
    end else begin
      ready_left <= ready_left - 1;
    end
    ready_tick <= ready_tick + 1'b1;
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
      RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:    out_ready <= ready_tick[2];
    endcase
  end

  // Present one echo item and hold it until taken. Inside a burst, valid
  // stays high and the next item follows at once; at the end of a burst,
  // drop valid and idle for a random gap.
  task automatic send_echo(input logic [ECHO_W-1:0] ticks);
    int unsigned gap;
    in_valid     <= 1'b1;
    in_echo_time <= ticks;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (burst_left == 0) begin
      in_valid   <= 1'b0;
      gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Hold off the sender until every predicted result item has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Raise the write and wait for the handshake; the caller drops valid
  // after the last write of a sequence.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write a full setting while the block is idle. Narrow registers get
  // junk above their width, and an undecoded index is hit every time.
  task automatic apply_setting(input logic [PRE_W-1:0]  pre,
                               input logic [OFF_W-1:0]  off,
                               input logic [GAIN_W-1:0] gain,
                               input logic [SPAN_W-1:0] span);
    logic [CFG_IDX_W-1:0] spare;
    drain();
    spare = CFG_IDX_SPARE + $urandom_range(0, (1 << CFG_IDX_W) - 1 - CFG_IDX_SPARE);
    write_reg(spare, CFG_DATA_W'($urandom));
    write_reg(CFG_TIMER_PRESCALE, {(CFG_DATA_W - PRE_W)'($urandom), pre});
    write_reg(CFG_MOTOR_OFFSET, {(CFG_DATA_W - OFF_W)'($urandom), off});
    write_reg(CFG_COUNTS_PER_US, gain);
    write_reg(CFG_BOARD_SPAN, {(CFG_DATA_W - SPAN_W)'($urandom), span});
    cfg_valid    <= 1'b0;
    cur_prescale = pre;
    cur_offset   = off;
    cur_gain     = gain;
    cur_span     = span;
    settings_applied++;
  endtask

  // Random echo times, mostly inside the accepted range, some straddling
  // its upper edge and the rest anywhere in 16 bits.
  task automatic run_random(input int unsigned count);
    longint max_motor;
    longint max_us;
    longint edge_ticks;
    longint pick;
    int     roll;
    if (cur_gain == 0) begin
      max_motor = 64'sd1 <<< 40;
    end else begin
      max_motor = (((longint'(cur_span >> 1) * 2 + 1) <<< FRAC_W) - 1) / cur_gain;
    end
    max_us = longint'(cur_offset) + max_motor;
    if (cur_prescale == 0) begin
      edge_ticks = ECHO_MAX;
    end else begin
      edge_ticks = ((max_us + 1) * (1 << US_SHIFT) - 1) / cur_prescale;
    end
    if (edge_ticks > ECHO_MAX) edge_ticks = ECHO_MAX;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        pick = $urandom_range(0, int'(edge_ticks));
      end else if (roll < 85) begin
        pick = edge_ticks + $urandom_range(0, 6) - 3;
      end else begin
        pick = $urandom_range(0, ECHO_MAX);
      end
      if (pick < 0) pick = 0;
      if (pick > ECHO_MAX) pick = ECHO_MAX;
      send_echo(ECHO_W'(pick));
      // Now and then let the pipeline run dry mid-phase.
      if ($urandom_range(0, 99) < 3) drain();
    end
  endtask

  task automatic run_phase(input logic [PRE_W-1:0]  pre,
                           input logic [OFF_W-1:0]  off,
                           input logic [GAIN_W-1:0] gain,
                           input logic [SPAN_W-1:0] span,
                           input int unsigned       count);
    apply_setting(pre, off, gain, span);
    run_random(count);
  endtask

  // Fail the run if it hangs.
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    items_sent       = 0;
    settings_applied = 0;
    burst_left       = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: 4 us per tick, unit gain, half span 5000, so 2500
    // ticks is the last accepted time.
    send_echo(16'd0);
    send_echo(16'd1);
    send_echo(16'd2500);
    send_echo(16'd2501);
    send_echo(16'hFFFF);
    send_echo(16'd1250);
    send_echo(16'd2499);
    send_echo(16'hAAAA);
    send_echo(16'h5555);

    // Offset floor: up to 500 ticks the motor distance clamps to zero.
    apply_setting(PRE_W'(64), OFF_W'(2000), GAIN_RST, SPAN_RST);
    send_echo(16'd499);
    send_echo(16'd500);
    send_echo(16'd501);
    send_echo(16'd3000);
    send_echo(16'd3001);

    // Fill the window with long echoes under a tiny gain, then switch to
    // the largest gain and a minimal span so the average saturates high.
    apply_setting(PRE_W'(16), OFF_W'(0), GAIN_W'(1), SPAN_W'(16'hFFFF));
    send_echo(16'hFFFF);
    send_echo(16'hFFFE);
    send_echo(16'd60000);
    send_echo(16'd65000);
    send_echo(16'd64000);
    send_echo(16'd63000);
    send_echo(16'd62000);
    send_echo(16'hFFFF);
    apply_setting(PRE_W'(16), OFF_W'(0), GAIN_W'('1), SPAN_W'(2));
    send_echo(16'd0);
    send_echo(16'd1);

    // Extreme settings.
    run_phase(PRE_W'(1), OFF_W'(0), GAIN_RST, SPAN_W'(16'hFFFF), 25);
    run_phase(PRE_W'(1024), OFF_W'(16'hFFFF), GAIN_W'('1), SPAN_W'(2), 25);
    // Prescale zero and above its range are used as written.
    run_phase(PRE_W'(0), OFF_W'(0), GAIN_RST, SPAN_RST, 15);
    run_phase(PRE_W'(2047), OFF_W'(1000), GAIN_W'(1), SPAN_W'(16'hFFFF), 20);
    // Spans of zero and one leave only position zero.
    run_phase(PRE_W'(64), OFF_W'(0), GAIN_RST, SPAN_W'(0), 20);
    run_phase(PRE_W'(64), OFF_W'(0), GAIN_W'(1), SPAN_W'(1), 20);
    run_phase(PRE_W'(64), OFF_W'(0), GAIN_W'(0), SPAN_RST, 15);
    run_phase(PRE_W'(1024), OFF_W'(0), GAIN_W'('1), SPAN_W'(16'hFFFF), 20);

    // Random settings.
    for (int p = 0; p < 8; p++) begin
      run_phase(PRE_W'($urandom_range(1, 1024)),
                OFF_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000)),
                GAIN_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                    : $urandom_range(16384, 262144)),
                SPAN_W'($urandom_range(2, 65535)),
                45);
    end

    // Let the last results come back, then allow for any stray item.
    drain();
    repeat (40) @(posedge clk);

    $display("Covered %0d echo items across %0d register settings (reset included).",
             items_sent, settings_applied + 1);
    $display("Compared %0d result items, %0d of them in range.",
             checked_count, in_range_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
